### rtl/cc20_pkg.sv
// shared types, constants and round functions of the chacha20 stream xor core
package cc20_pkg;

   localparam int CC20_DOUBLE_ROUNDS = 10;
   localparam int CC20_WORDS         = 16;
   localparam int CC20_CSR_IDX_W     = 3;
   localparam int CC20_CSR_DATA_W    = 64;

   typedef logic [31:0] word_type;

   localparam word_type SIGMA [4] = '{
      32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574
   };

   // configuration register indexes
   typedef enum logic [CC20_CSR_IDX_W-1:0] {
      CSR_KEY_0_7    = 3'd0,
      CSR_KEY_8_15   = 3'd1,
      CSR_KEY_16_23  = 3'd2,
      CSR_KEY_24_31  = 3'd3,
      CSR_NONCE_0_7  = 3'd4,
      CSR_NONCE_8_11 = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ROUND,
      ST_FINAL,
      ST_EMIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic latch_item;   // hold accepted byte, a new block is needed
      logic emit_direct;  // result from the byte on the input port
      logic load_init;    // working words take the initial state
      logic do_round;     // one column or diagonal round
      logic diag;         // round is a diagonal round
      logic final_add;    // add initial state, block done
      logic emit_held;    // result from the held byte
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic need_block;   // byte on the input port needs a fresh block
      logic out_free;     // output register can take a result this cycle
   } status_type;

   typedef struct packed {
      word_type a;
      word_type b;
      word_type c;
      word_type d;
   } quad_type;

   function automatic word_type cc20_rotl(input word_type v, input int n);
      return (v << n) | (v >> (32 - n));
   endfunction

   function automatic quad_type cc20_quarter(input quad_type q);
      quad_type r;
      r = q;
      r.a = r.a + r.b; r.d = cc20_rotl(r.d ^ r.a, 16);
      r.c = r.c + r.d; r.b = cc20_rotl(r.b ^ r.c, 12);
      r.a = r.a + r.b; r.d = cc20_rotl(r.d ^ r.a, 8);
      r.c = r.c + r.d; r.b = cc20_rotl(r.b ^ r.c, 7);
      return r;
   endfunction

endpackage

### rtl/cc20_req_if.sv
// input byte channel
interface cc20_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       message_start;
   logic       message_end;

   modport source (output valid, data_byte, message_start, message_end, input ready);
   modport sink   (input valid, data_byte, message_start, message_end, output ready);
endinterface

### rtl/cc20_rsp_if.sv
// result byte channel
interface cc20_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] result_byte;
   logic       result_end;

   modport source (output valid, result_byte, result_end, input ready);
   modport sink   (input valid, result_byte, result_end, output ready);
endinterface

### rtl/cc20_csr_if.sv
// configuration write channel
interface cc20_csr_if
   import cc20_pkg::*;
;
   logic                       valid;
   logic                       ready;
   logic [CC20_CSR_IDX_W-1:0]  index;
   logic [CC20_CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### rtl/cc20_ctrl.sv
// controller state machine of the chacha20 stream xor core
module cc20_ctrl
   import cc20_pkg::*;
#(
   parameter int DOUBLE_ROUNDS = CC20_DOUBLE_ROUNDS
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam int NUM_ROUNDS = 2 * DOUBLE_ROUNDS;
   localparam int RND_W      = $clog2(NUM_ROUNDS);
   localparam logic [RND_W-1:0] LAST_ROUND = RND_W'(NUM_ROUNDS - 1);

   state_type        state_ff, state_in;
   logic [RND_W-1:0] round_ff, round_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         round_ff <= '0;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      round_in  = round_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = status.out_free;
            if (req_valid && status.out_free) begin
               if (status.need_block) begin
                  cmd.latch_item = 1'b1;
                  state_in       = ST_LOAD;
               end else begin
                  cmd.emit_direct = 1'b1;
               end
            end
         end
         ST_LOAD: begin
            cmd.load_init = 1'b1;
            round_in      = '0;
            state_in      = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.do_round = 1'b1;
            cmd.diag     = round_ff[0];
            round_in     = round_ff + 1'b1;
            if (round_ff == LAST_ROUND) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            cmd.final_add = 1'b1;
            state_in      = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit_held = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_ready_only_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == ST_IDLE)
      else $error("input ready outside idle");

   a_rounds_then_final: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && round_ff == LAST_ROUND) |=> state_ff == ST_FINAL)
      else $error("round sequence did not end in final add");

   a_round_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROUND |-> round_ff <= LAST_ROUND)
      else $error("round counter out of range");

endmodule

### rtl/cc20_dp.sv
// datapath: key and nonce registers, working words, round unit, output register
module cc20_dp
   import cc20_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  cmd_type                    cmd,
   output status_type                 status,
   input  logic                       csr_write,
   input  logic [CC20_CSR_IDX_W-1:0]  csr_index,
   input  logic [CC20_CSR_DATA_W-1:0] csr_data,
   input  logic [7:0]                 data_byte,
   input  logic                       message_start,
   input  logic                       message_end,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [7:0]                 result_byte,
   output logic                       result_end
);

   logic [63:0] key_ff [4];
   logic [63:0] nonce_lo_ff;
   logic [31:0] nonce_hi_ff;

   word_type    counter_ff, counter_in;
   logic [5:0]  pos_ff, pos_in;
   logic        ks_ready_ff, ks_ready_in;
   logic        rsp_valid_ff, rsp_valid_in;

   word_type    words_ff [CC20_WORDS];
   word_type    words_in [CC20_WORDS];
   word_type    init_w   [CC20_WORDS];
   word_type    round_w  [CC20_WORDS];

   logic [7:0]  held_byte_ff;
   logic        held_end_ff;
   logic [7:0]  result_byte_ff, result_byte_in;
   logic        result_end_ff, result_end_in;

   logic        emit;
   logic        emit_end;
   logic [7:0]  emit_byte;
   word_type    ks_word;
   logic [7:0]  ks_byte;

   assign emit = cmd.emit_direct || cmd.emit_held;

   assign status.need_block = message_start || !ks_ready_ff;
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   // initial state of a block
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         init_w[i]         = SIGMA[i];
         init_w[4 + 2 * i] = key_ff[i][31:0];
         init_w[5 + 2 * i] = key_ff[i][63:32];
      end
      init_w[12] = counter_ff;
      init_w[13] = nonce_lo_ff[31:0];
      init_w[14] = nonce_lo_ff[63:32];
      init_w[15] = nonce_hi_ff;
   end

   // one column round or one diagonal round, four quarter rounds side by side
   always_comb begin
      quad_type q;
      quad_type r;
      int       ib;
      int       ic;
      int       id;
      round_w = words_ff;
      for (int i = 0; i < 4; i++) begin
         if (cmd.diag) begin
            ib = 4 + ((i + 1) % 4);
            ic = 8 + ((i + 2) % 4);
            id = 12 + ((i + 3) % 4);
         end else begin
            ib = 4 + i;
            ic = 8 + i;
            id = 12 + i;
         end
         q.a = words_ff[i];
         q.b = words_ff[ib];
         q.c = words_ff[ic];
         q.d = words_ff[id];
         r   = cc20_quarter(q);
         round_w[i]  = r.a;
         round_w[ib] = r.b;
         round_w[ic] = r.c;
         round_w[id] = r.d;
      end
   end

   always_comb begin
      for (int i = 0; i < CC20_WORDS; i++) begin
         if (cmd.load_init) begin
            words_in[i] = init_w[i];
         end else if (cmd.do_round) begin
            words_in[i] = round_w[i];
         end else if (cmd.final_add) begin
            words_in[i] = words_ff[i] + init_w[i];
         end else begin
            words_in[i] = words_ff[i];
         end
      end
   end

   // keystream byte, little-endian inside each word
   assign ks_word   = words_ff[pos_ff[5:2]];
   assign ks_byte   = ks_word[{pos_ff[1:0], 3'b000} +: 8];
   assign emit_byte = cmd.emit_held ? held_byte_ff : data_byte;
   assign emit_end  = cmd.emit_held ? held_end_ff : message_end;

   always_comb begin
      counter_in     = counter_ff;
      pos_in         = pos_ff;
      ks_ready_in    = ks_ready_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      result_byte_in = result_byte_ff;
      result_end_in  = result_end_ff;
      if (cmd.latch_item && message_start) begin
         counter_in = '0;
         pos_in     = '0;
      end
      if (cmd.final_add) begin
         counter_in  = counter_ff + 1'b1;
         ks_ready_in = 1'b1;
      end
      if (emit) begin
         rsp_valid_in   = 1'b1;
         result_byte_in = emit_byte ^ ks_byte;
         result_end_in  = emit_end;
         pos_in         = pos_ff + 1'b1;
         if (pos_ff == 6'h3f) begin
            ks_ready_in = 1'b0;
         end
         if (emit_end) begin
            counter_in  = '0;
            pos_in      = '0;
            ks_ready_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff   <= '0;
         pos_ff       <= '0;
         ks_ready_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         nonce_lo_ff  <= '0;
         nonce_hi_ff  <= '0;
         for (int i = 0; i < 4; i++) begin
            key_ff[i] <= '0;
         end
      end else begin
         counter_ff   <= counter_in;
         pos_ff       <= pos_in;
         ks_ready_ff  <= ks_ready_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            case (csr_index)
               CSR_KEY_0_7:    key_ff[0]   <= csr_data;
               CSR_KEY_8_15:   key_ff[1]   <= csr_data;
               CSR_KEY_16_23:  key_ff[2]   <= csr_data;
               CSR_KEY_24_31:  key_ff[3]   <= csr_data;
               CSR_NONCE_0_7:  nonce_lo_ff <= csr_data;
               CSR_NONCE_8_11: nonce_hi_ff <= csr_data[31:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < CC20_WORDS; i++) begin
         words_ff[i] <= words_in[i];
      end
      if (cmd.latch_item) begin
         held_byte_ff <= data_byte;
         held_end_ff  <= message_end;
      end
      result_byte_ff <= result_byte_in;
      result_end_ff  <= result_end_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign result_byte = result_byte_ff;
   assign result_end  = result_end_ff;

   a_emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      emit |-> status.out_free)
      else $error("result written over a pending transaction");

   a_final_sets_ready: assert property (@(posedge clock) disable iff (reset)
      cmd.final_add |=> ks_ready_ff)
      else $error("keystream not marked ready after block");

   a_direct_has_block: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_direct |-> (ks_ready_ff && !message_start))
      else $error("direct result without a live keystream block");

endmodule

### rtl/chacha20_stream_xor_core.sv
// top level of the chacha20 stream xor core
//
// usage
// - req_chan carries one data byte per transaction with message_start and
//   message_end marks; rsp_chan returns the byte xored with the keystream and
//   a copy of the end mark, one result per input transaction, in order
// - csr_chan writes key and nonce registers; index 0..3 key, 4..5 nonce;
//   write only while no transaction is in flight; csr_chan.ready is always high
// - a byte inside a live keystream block is taken and its result shows in the
//   output register the next cycle: one byte per cycle unless rsp_chan stalls
// - a byte that starts a message, or follows 64 used bytes, first makes a
//   block: a load step, 2*DOUBLE_ROUNDS rounds (one column or diagonal round
//   a cycle on the shared round unit), a final add step, then the result
// - the block counter starts at 0 per message and wraps modulo 2^32; after an
//   end mark the next byte begins a new message
// - reset (synchronous) clears key and nonce registers, counter and keystream
//   state; no clearing pass is needed
// - a stalled receiver holds the output register; a new byte is accepted
//   while the pending result is being taken in the same cycle
module chacha20_stream_xor_core
   import cc20_pkg::*;
#(
   parameter int DOUBLE_ROUNDS = CC20_DOUBLE_ROUNDS
) (
   input  logic      clock,
   input  logic      reset,
   cc20_req_if.sink  req_chan,
   cc20_rsp_if.source rsp_chan,
   cc20_csr_if.sink  csr_chan
);

   cmd_type    cmd;
   status_type status;
   logic       req_ready;

   // controller: sequences block generation and result writes
   cc20_ctrl #(
      .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: state words, round unit, keystream select, output register
   cc20_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .csr_write     (csr_chan.valid),
      .csr_index     (csr_chan.index),
      .csr_data      (csr_chan.data),
      .data_byte     (req_chan.data_byte),
      .message_start (req_chan.message_start),
      .message_end   (req_chan.message_end),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .result_byte   (rsp_chan.result_byte),
      .result_end    (rsp_chan.result_end)
   );

   assign req_chan.ready = req_ready;
   // register writes never stall
   assign csr_chan.ready = 1'b1;

endmodule

### tb/sv/chacha20_stream_xor_core_test.sv
`timescale 1ns / 1ps
// self-checking testbench of the chacha20 stream xor core, byte stream against a keystream predictor
module chacha20_stream_xor_core_test
   import cc20_pkg::*;
;

   localparam int DOUBLE_ROUND_COUNT = 10;
   // settle time after a drain, long enough for a block with margin on top
   localparam int SETTLE_CYCLES      = 2 * DOUBLE_ROUND_COUNT + 10;
   localparam int HOLD_CYCLES        = 400;
   localparam int WATCHDOG_LIMIT     = 4000;
   localparam int PHASE_COUNT        = 6;
   localparam int PHASE_ITEMS        = 115;
   localparam int IDLE_PERCENT       = 26;

   // indexes past the last register, the core must ignore them
   localparam logic [CC20_CSR_IDX_W-1:0] CSR_SPARE_6 = 3'd6;
   localparam logic [CC20_CSR_IDX_W-1:0] CSR_SPARE_7 = 3'd7;

   // "expand 32-byte k"
   localparam word_type EXPAND_WORDS [4] = '{
      32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574
   };

   typedef struct packed {
      logic [7:0] result_byte;
      logic       result_end;
   } xor_result_type;

   // what the sender knows about a byte it offers
   typedef struct packed {
      logic           typed;
      xor_result_type value;
   } offer_note_type;

   typedef struct {
      logic [7:0] data_byte;
      logic       message_start;
      logic       message_end;
      logic       typed;
      logic [7:0] typed_byte;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cc20_req_if req_chan ();
   cc20_rsp_if rsp_chan ();
   cc20_csr_if csr_chan ();

   chacha20_stream_xor_core #(
      .DOUBLE_ROUNDS(DOUBLE_ROUND_COUNT)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // keystream predictor state, touched only by the monitor
   // ---------------------------------------------------------------
   logic [63:0] key_pairs [4];
   logic [63:0] nonce_low;
   logic [31:0] nonce_high;
   logic [31:0] block_count;
   logic [7:0]  stream_bytes [64];
   logic [5:0]  stream_pos;
   logic        stream_live;

   offer_note_type offered_notes [$];
   xor_result_type xor_expected [$];
   int             mismatch_count = 0;
   int             idle_cycles = 0;

   // knobs shared by the sender, the receiver and the phase sequencer
   logic steady_run = 1'b0;
   int   hold_requests = 0;

   // zero-key, zero-nonce, counter 0 keystream starts 76 b8 e0 ad, so the
   // first rows of the table can carry their result directly
   stim_row_type directed_rows [18] = '{
      '{8'h00, 1'b1, 1'b0, 1'b1, 8'h76},   // min data on a message start
      '{8'hff, 1'b0, 1'b0, 1'b1, 8'h47},   // max data
      '{8'h00, 1'b0, 1'b0, 1'b1, 8'he0},
      '{8'h80, 1'b0, 1'b1, 1'b1, 8'h2d},   // end of a four byte message
      '{8'h5a, 1'b1, 1'b1, 1'b1, 8'h2c},   // start and end on one byte
      '{8'h01, 1'b0, 1'b0, 1'b1, 8'h77},   // no start mark after an end
      '{8'h00, 1'b0, 1'b0, 1'b1, 8'hb8},
      '{8'hff, 1'b1, 1'b0, 1'b1, 8'h89},   // restart in the middle of a message
      '{8'h00, 1'b0, 1'b0, 1'b1, 8'hb8},
      '{8'h00, 1'b0, 1'b0, 1'b1, 8'he0},
      '{8'h7f, 1'b0, 1'b0, 1'b1, 8'hd2},
      '{8'h00, 1'b0, 1'b0, 1'b0, 8'h00},
      '{8'hff, 1'b0, 1'b0, 1'b0, 8'h00},
      '{8'h55, 1'b0, 1'b0, 1'b0, 8'h00},
      '{8'haa, 1'b0, 1'b1, 1'b0, 8'h00},
      '{8'hff, 1'b1, 1'b1, 1'b1, 8'h89},
      '{8'h00, 1'b1, 1'b0, 1'b1, 8'h76},
      '{8'h33, 1'b0, 1'b1, 1'b1, 8'h8b}
   };

   function automatic word_type rotl_word(input word_type v, input int n);
      return (v << n) | (v >> (32 - n));
   endfunction

   function automatic logic [127:0] mix_quad(input logic [127:0] abcd);
      word_type a, b, c, d;
      {a, b, c, d} = abcd;
      a = a + b; d = rotl_word(d ^ a, 16);
      c = c + d; b = rotl_word(b ^ c, 12);
      a = a + b; d = rotl_word(d ^ a, 8);
      c = c + d; b = rotl_word(b ^ c, 7);
      return {a, b, c, d};
   endfunction

   // one 64-byte block from the current key, nonce and counter
   function automatic void build_keystream();
      word_type seed [16];
      word_type x [16];
      word_type w;
      int ia, ib, ic, id;
      for (int k = 0; k < 4; k++) begin
         seed[k]         = EXPAND_WORDS[k];
         seed[4 + 2 * k] = key_pairs[k][31:0];
         seed[5 + 2 * k] = key_pairs[k][63:32];
      end
      seed[12] = block_count;
      seed[13] = nonce_low[31:0];
      seed[14] = nonce_low[63:32];
      seed[15] = nonce_high;
      x = seed;
      for (int r = 0; r < DOUBLE_ROUND_COUNT; r++) begin
         // half 0 works on columns, half 1 on diagonals
         for (int half = 0; half < 2; half++) begin
            for (int i = 0; i < 4; i++) begin
               ia = i;
               ib = 4 + (i + half) % 4;
               ic = 8 + (i + 2 * half) % 4;
               id = 12 + (i + 3 * half) % 4;
               {x[ia], x[ib], x[ic], x[id]} = mix_quad({x[ia], x[ib], x[ic], x[id]});
            end
         end
      end
      for (int k = 0; k < 16; k++) begin
         w = x[k] + seed[k];
         for (int j = 0; j < 4; j++)
            stream_bytes[4 * k + j] = w[8 * j +: 8];
      end
      block_count = block_count + 32'd1;
      stream_live = 1'b1;
   endfunction

   function automatic xor_result_type next_keystream_xor(input logic [7:0] data,
                                                         input logic start, input logic last);
      xor_result_type res;
      if (start) begin
         block_count = '0;
         stream_pos  = '0;
         stream_live = 1'b0;
      end
      if (!stream_live)
         build_keystream();
      res.result_byte = data ^ stream_bytes[stream_pos];
      res.result_end  = last;
      stream_pos = stream_pos + 6'd1;
      if (stream_pos == '0)
         stream_live = 1'b0;
      if (last) begin
         block_count = '0;
         stream_pos  = '0;
         stream_live = 1'b0;
      end
      return res;
   endfunction

   function automatic void apply_register(input logic [CC20_CSR_IDX_W-1:0] idx,
                                          input logic [CC20_CSR_DATA_W-1:0] value);
      case (idx)
         CSR_KEY_0_7:    key_pairs[0] = value;
         CSR_KEY_8_15:   key_pairs[1] = value;
         CSR_KEY_16_23:  key_pairs[2] = value;
         CSR_KEY_24_31:  key_pairs[3] = value;
         CSR_NONCE_0_7:  nonce_low    = value;
         CSR_NONCE_8_11: nonce_high   = value[31:0];
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------
   // monitor: predicts on every accepted input transaction, checks
   // every accepted result transaction, and runs the watchdog
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      xor_result_type got, want;
      offer_note_type note;
      logic moved;
      if (reset) begin
         for (int k = 0; k < 4; k++)
            key_pairs[k] = '0;
         nonce_low   = '0;
         nonce_high  = '0;
         block_count = '0;
         stream_pos  = '0;
         stream_live = 1'b0;
         idle_cycles = 0;
      end else begin
         moved = 1'b0;
         if (csr_chan.valid && csr_chan.ready) begin
            apply_register(csr_chan.index, csr_chan.data);
            moved = 1'b1;
         end
         // input side first so the predictor is ahead of the result side
         if (req_chan.valid && req_chan.ready) begin
            want = next_keystream_xor(req_chan.data_byte, req_chan.message_start,
                                      req_chan.message_end);
            if (offered_notes.size() != 0) begin
               note = offered_notes.pop_front();
               if (note.typed)
                  want = note.value;
            end
            xor_expected.push_back(want);
            moved = 1'b1;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.result_byte = rsp_chan.result_byte;
            got.result_end  = rsp_chan.result_end;
            if (xor_expected.size() == 0) begin
               $error("result_byte: expected none, got %h (no byte outstanding)",
                      got.result_byte);
               mismatch_count++;
            end else begin
               want = xor_expected.pop_front();
               if (got.result_byte !== want.result_byte) begin
                  $error("result_byte: expected %h, got %h", want.result_byte,
                         got.result_byte);
                  mismatch_count++;
               end
               if (got.result_end !== want.result_end) begin
                  $error("result_end: expected %b, got %b", want.result_end,
                         got.result_end);
                  mismatch_count++;
               end
            end
            moved = 1'b1;
         end
         // nothing moving for too long means the core hung
         if (moved)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------
   // receiver: random stalls, none during a steady run, and a long
   // hold-off on request so the core backs up into its input
   // ---------------------------------------------------------------
   initial begin : result_drain
      int hold_left = 0;
      int holds_done = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_done) begin
            holds_done = hold_requests;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (steady_run)
            rsp_chan.ready <= 1'b1;
         else
            rsp_chan.ready <= ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // ---------------------------------------------------------------
   // sender side helpers
   // ---------------------------------------------------------------
   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // offer one byte, with random gaps ahead of it, and hold it until taken;
   // valid stays high on return so back-to-back offers never drop it
   task automatic offer_byte(input logic [7:0] data, input logic start, input logic last,
                             input logic typed, input logic [7:0] typed_byte);
      offer_note_type note;
      while (!steady_run && $urandom_range(99) < IDLE_PERCENT) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      note.typed             = typed;
      note.value.result_byte = typed_byte;
      note.value.result_end  = last;
      offered_notes.push_back(note);
      req_chan.valid         <= 1'b1;
      req_chan.data_byte     <= data;
      req_chan.message_start <= start;
      req_chan.message_end   <= last;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // csr valid is left high; the caller lowers it after the last write
   task automatic write_reg(input logic [CC20_CSR_IDX_W-1:0] idx,
                            input logic [CC20_CSR_DATA_W-1:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      do @(posedge clock); while (!csr_chan.ready);
   endtask

   task automatic write_all(input logic [63:0] k0, input logic [63:0] k1,
                            input logic [63:0] k2, input logic [63:0] k3,
                            input logic [63:0] n0, input logic [31:0] n1);
      write_reg(CSR_KEY_0_7, k0);
      write_reg(CSR_KEY_8_15, k1);
      write_reg(CSR_KEY_16_23, k2);
      write_reg(CSR_KEY_24_31, k3);
      write_reg(CSR_NONCE_0_7, n0);
      // upper half of the short nonce register stays zero
      write_reg(CSR_NONCE_8_11, {32'h0, n1});
   endtask

   task automatic load_phase_registers(input int phase);
      case (phase)
         1: write_all('1, '1, '1, '1, '1, '1);
         // a single key register plus writes to the unused indexes
         3: begin
            write_reg(CSR_KEY_16_23, rand64());
            write_reg(CSR_SPARE_6, rand64());
            write_reg(CSR_SPARE_7, rand64());
         end
         5: write_all('0, '0, '0, '0, '0, '0);
         default: write_all(rand64(), rand64(), rand64(), rand64(), rand64(), $urandom);
      endcase
      csr_chan.valid <= 1'b0;
   endtask

   // every offered byte answered, then let the core go quiet
   task automatic drain_and_settle();
      while (offered_notes.size() != 0 || xor_expected.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------
   // phase sequencer: directed table on the reset key, then random
   // message streams under several key and nonce settings
   // ---------------------------------------------------------------
   initial begin : stimulus
      int         msg_left;
      logic       msg_first;
      logic       mark_start;
      logic       mark_end;
      int         pick;
      msg_left  = 0;
      msg_first = 1'b0;
      req_chan.valid         <= 1'b0;
      req_chan.data_byte     <= '0;
      req_chan.message_start <= 1'b0;
      req_chan.message_end   <= 1'b0;
      csr_chan.valid         <= 1'b0;
      csr_chan.index         <= CSR_KEY_0_7;
      csr_chan.data          <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         offer_byte(directed_rows[i].data_byte, directed_rows[i].message_start,
                    directed_rows[i].message_end, directed_rows[i].typed,
                    directed_rows[i].typed_byte);
      req_chan.valid <= 1'b0;

      for (int phase = 1; phase <= PHASE_COUNT; phase++) begin
         // phases may stop inside a message, so new keys also land mid block
         drain_and_settle();
         load_phase_registers(phase);
         steady_run = (phase == 1);
         if (phase == 2)
            hold_requests++;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (msg_left == 0) begin
               pick = $urandom_range(99);
               if (pick < 25)
                  msg_left = $urandom_range(8, 1);
               else if (pick < 75)
                  msg_left = $urandom_range(140, 9);
               else begin
                  // lengths around the block boundary
                  case ($urandom_range(3))
                     0: msg_left = 63;
                     1: msg_left = 64;
                     2: msg_left = 65;
                     default: msg_left = 128;
                  endcase
               end
               msg_first = 1'b1;
            end
            // mostly clean framing, with stray marks now and then
            mark_start = msg_first ? ($urandom_range(99) < 90) : ($urandom_range(99) < 2);
            mark_end   = (msg_left == 1) ? ($urandom_range(99) < 90)
                                         : ($urandom_range(99) < 2);
            offer_byte(8'($urandom_range(255)), mark_start, mark_end, 1'b0, 8'h00);
            msg_left--;
            msg_first = 1'b0;
         end
         req_chan.valid <= 1'b0;
      end
      steady_run = 1'b0;
      drain_and_settle();

      if (mismatch_count == 0 && xor_expected.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

### sim.f
rtl/cc20_pkg.sv
rtl/cc20_req_if.sv
rtl/cc20_rsp_if.sv
rtl/cc20_csr_if.sv
rtl/cc20_ctrl.sv
rtl/cc20_dp.sv
rtl/chacha20_stream_xor_core.sv
tb/sv/chacha20_stream_xor_core_test.sv
